// ===== rtl/core/bcpe_pkg.sv =====
// Shared types, constants and register map of the curve point evaluator.
`default_nettype none

package bcpe_pkg;

    localparam int T_FRAC_BITS_DEF = 16;
    localparam int COORD_W         = 32;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_DATA_W      = 64;
    localparam int NUM_POINTS      = 4;

    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_START  = 3'd1;
    localparam logic [2:0] REG_SECOND = 3'd2;
    localparam logic [2:0] REG_THIRD  = 3'd3;
    localparam logic [2:0] REG_FOURTH = 3'd4;

    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_QUAD  = 2'd1;
    localparam logic [1:0] KIND_CUBIC = 2'd2;

    typedef struct packed {
        logic [1:0]                          kind;
        logic [NUM_POINTS-1:0][COORD_W-1:0]  px;
        logic [NUM_POINTS-1:0][COORD_W-1:0]  py;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bezier_curve_point_eval.sv =====
// Curve point evaluator (line, quadratic, cubic) by a pipelined de Casteljau cascade.
// The done strobe is the last bit of the valid pipeline and marks the registered output point.
// Throughput: one t per cycle; busy is always low, three levels of two-stage lerps.
// Reset: clears the valid pipeline and all configuration registers to zero.
// The receiver cannot stall; results appear for exactly one cycle.
`default_nettype none

module bezier_curve_point_eval
    import bcpe_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [T_FRAC_BITS:0]   param_t,
    output logic                        done,
    output logic signed [COORD_W-1:0]   point_x,
    output logic signed [COORD_W-1:0]   point_y
);

    localparam int TW    = T_FRAC_BITS + 1;
    localparam int DEPTH = 8;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    cfg_t cfg;

    bcpe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [TW-1:0]    t_reg [5];
    logic [TW-1:0]    t_next;

    logic [COORD_W-1:0] l1x [3];
    logic [COORD_W-1:0] l1y [3];
    logic [COORD_W-1:0] l2x [2];
    logic [COORD_W-1:0] l2y [2];
    logic [COORD_W-1:0] l3x;
    logic [COORD_W-1:0] l3y;

    logic [COORD_W-1:0] lin_x_reg [4];
    logic [COORD_W-1:0] lin_y_reg [4];
    logic [COORD_W-1:0] quad_x_reg [2];
    logic [COORD_W-1:0] quad_y_reg [2];
    logic [COORD_W-1:0] out_x_next;
    logic [COORD_W-1:0] out_y_next;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;

    assign busy     = 1'b0;
    assign t_next   = (param_t > T_ONE) ? T_ONE : param_t;
    assign vld_next = {vld_reg[DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload pipeline: t for each level, and the shorter-curve results held to the output.
    always_ff @(posedge clk)
    begin
        t_reg[0] <= t_next;
        for (int i = 1; i < 5; i++)
        begin
            t_reg[i] <= t_reg[i-1];
        end
        lin_x_reg[0]  <= l1x[0];
        lin_y_reg[0]  <= l1y[0];
        for (int i = 1; i < 4; i++)
        begin
            lin_x_reg[i] <= lin_x_reg[i-1];
            lin_y_reg[i] <= lin_y_reg[i-1];
        end
        quad_x_reg[0] <= l2x[0];
        quad_y_reg[0] <= l2y[0];
        quad_x_reg[1] <= quad_x_reg[0];
        quad_y_reg[1] <= quad_y_reg[0];
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lvl1
            bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_x (
                .clk (clk), .a (cfg.px[g]), .b (cfg.px[g+1]), .t (t_reg[0]), .res (l1x[g])
            );
            bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_y (
                .clk (clk), .a (cfg.py[g]), .b (cfg.py[g+1]), .t (t_reg[0]), .res (l1y[g])
            );
        end
        for (g = 0; g < 2; g++)
        begin : g_lvl2
            bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_x (
                .clk (clk), .a (l1x[g]), .b (l1x[g+1]), .t (t_reg[2]), .res (l2x[g])
            );
            bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_y (
                .clk (clk), .a (l1y[g]), .b (l1y[g+1]), .t (t_reg[2]), .res (l2y[g])
            );
        end
    endgenerate

    bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lvl3_x (
        .clk (clk), .a (l2x[0]), .b (l2x[1]), .t (t_reg[4]), .res (l3x)
    );
    bcpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lvl3_y (
        .clk (clk), .a (l2y[0]), .b (l2y[1]), .t (t_reg[4]), .res (l3y)
    );

    // Undefined kind evaluates as a cubic.
    always_comb
    begin
        case (cfg.kind)
            KIND_LINE:
            begin
                out_x_next = lin_x_reg[3];
                out_y_next = lin_y_reg[3];
            end
            KIND_QUAD:
            begin
                out_x_next = quad_x_reg[1];
                out_y_next = quad_y_reg[1];
            end
            default:
            begin
                out_x_next = l3x;
                out_y_next = l3y;
            end
        endcase
    end

    assign done    = vld_reg[DEPTH-1];
    assign point_x = $signed(out_x_reg);
    assign point_y = $signed(out_y_reg);

endmodule

`default_nettype wire

// ===== rtl/core/bcpe_regs.sv =====
// Configuration register file with APB-style access.
`default_nettype none

module bcpe_regs
    import bcpe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [1:0]            kind_reg;
    logic [CFG_DATA_W-1:0] pt_reg [NUM_POINTS];
    logic [2:0]            reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_LINE;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                pt_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KIND:   kind_reg  <= pwdata[1:0];
                REG_START:  pt_reg[0] <= pwdata;
                REG_SECOND: pt_reg[1] <= pwdata;
                REG_THIRD:  pt_reg[2] <= pwdata;
                REG_FOURTH: pt_reg[3] <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KIND:   prdata = {{(CFG_DATA_W-2){1'b0}}, kind_reg};
            REG_START:  prdata = pt_reg[0];
            REG_SECOND: prdata = pt_reg[1];
            REG_THIRD:  prdata = pt_reg[2];
            REG_FOURTH: prdata = pt_reg[3];
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.kind = kind_reg;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            cfg.px[i] = pt_reg[i][CFG_DATA_W-1:COORD_W];
            cfg.py[i] = pt_reg[i][COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bcpe_lerp.sv =====
// Two-stage rounded linear interpolation a + round((b - a) * t).
`default_nettype none

module bcpe_lerp
    import bcpe_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic [COORD_W-1:0]        a,
    input  wire logic [COORD_W-1:0]        b,
    input  wire logic [T_FRAC_BITS:0]      t,
    output logic      [COORD_W-1:0]        res
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_FRAC_BITS + 2;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [COORD_W-1:0] a_reg;
    logic signed [PROD_W-1:0] rounded;
    logic        [COORD_W-1:0] res_next;
    logic        [COORD_W-1:0] res_reg;

    assign diff      = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    assign prod_next = PROD_W'(diff * $signed({1'b0, t}));

    // Half-LSB bias then floor: ties go toward +infinity.
    assign rounded  = (prod_reg + (PROD_W'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
    // Result lies between a and b, so modulo-2^32 addition is exact.
    assign res_next = a_reg + rounded[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== dv/tb_bezier_curve_point_eval.sv =====
// Self-checking testbench for the curve point evaluator: APB setup, t transfers, point checks.
`default_nettype none

module tb_bezier_curve_point_eval;
    import bcpe_pkg::*;

    localparam int          TFB        = T_FRAC_BITS_DEF;
    localparam int          TW         = TFB + 1;
    localparam longint      T_ONE      = longint'(1) <<< TFB;
    localparam int          LATENCY    = 8;
    localparam int          LIMIT      = 400000;
    localparam int          ITEM_GOAL  = 500;
    localparam logic [2:0]  REG_SPARE  = 3'd5;
    localparam logic [1:0]  KIND_UNDEF = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Shadow of the curve registers, the de Casteljau predictor and the queue of awaited points
    class curve_point_board;
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  ctl_x [NUM_POINTS];
        logic signed [COORD_W-1:0]  ctl_y [NUM_POINTS];
        point_t                     awaited_points [$];
        int                         mismatches;
        int                         points_seen;
        int                         items_by_kind [4];

        function new();
            kind = KIND_LINE;
            foreach (ctl_x[i])
            begin
                ctl_x[i] = '0;
                ctl_y[i] = '0;
            end
            mismatches  = 0;
            points_seen = 0;
            foreach (items_by_kind[i])
                items_by_kind[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KIND:   kind = data[1:0];
                REG_START,
                REG_SECOND,
                REG_THIRD,
                REG_FOURTH:
                begin
                    ctl_x[2'(idx - REG_START)] = data[63:32];
                    ctl_y[2'(idx - REG_START)] = data[31:0];
                end
                default: ;
            endcase
        endfunction

        // a + round((b - a) * t / ONE), ties upward
        function longint blend(longint a, longint b, longint t);
            longint prod;
            prod = (b - a) * t + (longint'(1) <<< (TFB - 1));
            return a + (prod >>> TFB);
        endfunction

        function logic signed [COORD_W-1:0] axis_point(longint c0, longint c1, longint c2,
                                                       longint c3, longint t);
            longint a;
            longint b;
            longint c;
            longint v;
            if (kind == KIND_LINE)
                v = blend(c0, c1, t);
            else if (kind == KIND_QUAD)
                v = blend(blend(c0, c1, t), blend(c1, c2, t), t);
            else
            begin
                a = blend(c0, c1, t);
                b = blend(c1, c2, t);
                c = blend(c2, c3, t);
                v = blend(blend(a, b, t), blend(b, c, t), t);
            end
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[COORD_W-1:0];
        endfunction

        function void note_param(logic [TFB:0] t_raw);
            longint t;
            point_t p;
            t = longint'(t_raw);
            if (t > T_ONE)
                t = T_ONE;
            p.x = axis_point(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], t);
            p.y = axis_point(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], t);
            awaited_points.push_back(p);
            items_by_kind[kind]++;
        endfunction

        function void check_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
            point_t p;
            points_seen++;
            if (awaited_points.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected point x=%0d y=%0d", x, y);
                mismatches++;
                return;
            end
            p = awaited_points.pop_front();
            if (p.x !== x || p.y !== y)
            begin
                if (mismatches < 10)
                    $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             p.x, p.y, x, y);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_points.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [CFG_ADDR_W-1:0]          paddr;
    logic [CFG_DATA_W-1:0]          pwdata;
    logic [CFG_DATA_W-1:0]          prdata;
    logic                           pready;
    logic                           start;
    logic                           busy;
    logic [TFB:0]                   param_t;
    logic                           done;
    logic signed [COORD_W-1:0]      point_x;
    logic signed [COORD_W-1:0]      point_y;

    curve_point_board   board = new();
    int                 items_sent;
    int                 cycle_count;

    bezier_curve_point_eval u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .param_t (param_t),
        .done    (done),
        .point_x (point_x),
        .point_y (point_y)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Register writes, accepted t transfers and result strobes, all sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_point(point_x, point_y);
            if (psel && penable && pwrite && pready)
                board.write_reg(paddr[5:3], pwdata);
            if (start && !busy)
                board.note_param(param_t);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout with %0d points outstanding", board.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // deselects and waits idle after each access so consecutive writes never overlap
    task automatic reg_write(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // start stays high across back-to-back transfers; lowered when a gap follows, and by drain
    task automatic send_t(logic [TFB:0] t, int gap);
        start   <= 1'b1;
        param_t <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return COORD_W'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [TFB:0] rand_t();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return TW'($urandom_range(0, int'(T_ONE)));
        else if (pick == 7)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return TW'(1);
                2:       return TW'(T_ONE - 1);
                default: return TW'(T_ONE);
            endcase
        end
        return TW'($urandom());
    endfunction

    function automatic int rand_gap(bit quiet);
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 0;
        else if (pick < 19)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        logic [TFB:0] edge_ts [7];
        logic [TFB:0] few_ts [3];
        logic [1:0]   kind_sel;
        int           n_items;
        bit           quiet;
        int           phases;

        edge_ts = '{'0, TW'(1), TW'(T_ONE / 2), TW'(T_ONE - 1), TW'(T_ONE), TW'(T_ONE + 1),
                    {TW{1'b1}}};
        few_ts  = '{'0, TW'(T_ONE / 2), TW'(T_ONE)};
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        param_t = '0;
        items_sent  = 0;
        phases      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: zero line
        send_t('0, 0);
        send_t(TW'(T_ONE), 1);
        drain();

        // opposite extremes on every control point, cubic
        reg_write(REG_KIND, {62'd0, KIND_CUBIC});
        reg_write(REG_START,  {32'h7FFF_FFFF, 32'h8000_0000});
        reg_write(REG_SECOND, {32'h8000_0000, 32'h7FFF_FFFF});
        reg_write(REG_THIRD,  {32'h7FFF_FFFF, 32'h8000_0000});
        reg_write(REG_FOURTH, {32'h8000_0000, 32'h7FFF_FFFF});
        // out-of-range index must leave everything untouched
        reg_write(REG_SPARE,  64'hFFFF_FFFF_FFFF_FFFF);
        foreach (edge_ts[i])
            send_t(edge_ts[i], 0);
        drain();

        // line, quadratic and the undefined kind; upper bits of the kind write are junk
        for (int k = 0; k < 3; k++)
        begin
            kind_sel = (k == 0) ? KIND_LINE : (k == 1) ? KIND_QUAD : KIND_UNDEF;
            reg_write(REG_KIND, {$urandom(), 30'($urandom_range(0, 32'h3FFF_FFFF)), kind_sel});
            reg_write(REG_FOURTH, {rand_coord(), rand_coord()});
            foreach (few_ts[i])
                send_t(few_ts[i], k);
            drain();
        end

        // random phases: fresh curve each time, drained before the next setup
        while (items_sent < ITEM_GOAL + 20)
        begin
            phases++;
            reg_write(REG_KIND, {$urandom(), 30'($urandom()), 2'($urandom_range(0, 3))});
            reg_write(REG_START,  {rand_coord(), rand_coord()});
            reg_write(REG_SECOND, {rand_coord(), rand_coord()});
            reg_write(REG_THIRD,  {rand_coord(), rand_coord()});
            reg_write(REG_FOURTH, {rand_coord(), rand_coord()});
            if ($urandom_range(0, 7) == 0)
                reg_write(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom(), $urandom()});
            quiet   = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(20, 60);
            repeat (n_items)
                send_t(rand_t(), rand_gap(quiet));
            drain();
        end

        $display("%0d t transfers over %0d random curves, %0d points checked",
                 items_sent, phases, board.points_seen);
        $display("transfers per kind: line %0d, quadratic %0d, cubic %0d, undefined %0d",
                 board.items_by_kind[0], board.items_by_kind[1],
                 board.items_by_kind[2], board.items_by_kind[3]);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d points outstanding",
                     board.mismatches, board.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== bezier_curve_point_eval.f =====
rtl/core/bcpe_pkg.sv
rtl/core/bcpe_regs.sv
rtl/core/bcpe_lerp.sv
rtl/core/bezier_curve_point_eval.sv
dv/tb_bezier_curve_point_eval.sv
